@@ sv/sqmm_pkg.sv @@
// Shared types and constants for the square matrix multiply core.
package sqmm_pkg;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 3;
    localparam int ELEM_W   = 16;
    localparam int MUL_W    = 2 * ELEM_W;
    localparam int PROD_W   = 36;
    localparam int SIZE_W   = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

@@ sv/sqmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sqmm_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/square_matrix_multiply_core.sv @@
// Square matrix multiply core: element loads into A and B, then C = A * B in row-major order.
//
// Write items store one element of A or B. A compute item keeps the input side
// busy while every element of C is produced by one shared 16x16 multiplier and
// a 36-bit accumulator, fed from two RAMs with one read port each. For each
// element of C the core issues n reads, then passes the read, multiply,
// accumulate and hand-off stages; a stall on the result channel holds the
// compute. n is the configured size limited to MAX_DIM. The result register
// lets the last product wait for the downstream side while new items are
// already accepted.
module square_matrix_multiply_core
    import sqmm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [SIZE_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OPCODE_W-1:0]      s_opcode,
    input  logic [POS_W-1:0]         s_row,
    input  logic [POS_W-1:0]         s_col,
    input  logic signed [ELEM_W-1:0] s_element_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [POS_W-1:0]         m_out_row,
    output logic [POS_W-1:0]         m_out_col,
    output logic signed [PROD_W-1:0] m_product_value,
    output logic                     m_last
);

    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] size_in_use_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  n_clip;
    logic [CNT_W-1:0]  n_last;

    logic s_accept;
    logic wr_in_range;
    logic wr_en_a, wr_en_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [ELEM_W-1:0] rd_data_a, rd_data_b;

    logic issue;
    logic s1_vld_reg, s1_first_reg, s1_last_reg;
    logic s2_vld_reg, s2_first_reg, s2_last_reg;
    logic done_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [PROD_W-1:0] acc_reg;

    logic out_free;
    logic out_load;
    logic m_valid_reg;
    logic [POS_W-1:0] m_out_row_reg, m_out_col_reg;
    logic signed [PROD_W-1:0] m_product_value_reg;
    logic m_last_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Sizes above the storage dimension are taken as the storage dimension.
    assign n_clip = (32'(size_in_use_reg) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                           : CNT_W'(size_in_use_reg);
    assign n_last = n_reg - CNT_W'(1);

    // Element writes.
    assign wr_in_range = (32'(s_row) < 32'(MAX_DIM)) && (32'(s_col) < 32'(MAX_DIM));
    assign wr_addr = ADDR_W'(s_row) * ADDR_W'(MAX_DIM) + ADDR_W'(s_col);
    assign wr_en_a = s_accept && wr_in_range && (s_opcode == OP_WRITE_A);
    assign wr_en_b = s_accept && wr_in_range && (s_opcode == OP_WRITE_B);

    // A is walked along row i, B down column j.
    assign rd_addr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign rd_addr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    sqmm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (s_element_value),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    sqmm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (s_element_value),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    assign issue    = (state_reg == ST_ISSUE);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_opcode == OP_COMPUTE) && (n_clip != '0)) begin
                    n_next     = n_clip;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_reg == n_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (done_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (j_reg == n_last) begin
                        j_next = '0;
                        if (i_reg == n_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_ISSUE;
                        end
                    end else begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            size_in_use_reg <= SIZE_RESET;
            n_reg           <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            done_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg && s2_last_reg;
            if (cfg_wr_en) begin
                size_in_use_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Multiply-accumulate datapath: read, multiply, accumulate, and result register load.
    always_ff @(posedge aclk) begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == n_last);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        mul_reg      <= MUL_W'($signed(rd_data_a)) * MUL_W'($signed(rd_data_b));
        if (s2_vld_reg) begin
            if (s2_first_reg) begin
                acc_reg <= PROD_W'(mul_reg);
            end else begin
                acc_reg <= acc_reg + PROD_W'(mul_reg);
            end
        end
        if (out_load) begin
            m_out_row_reg       <= POS_W'(i_reg);
            m_out_col_reg       <= POS_W'(j_reg);
            m_product_value_reg <= acc_reg;
            m_last_reg          <= (i_reg == n_last) && (j_reg == n_last);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_row       = m_out_row_reg;
    assign m_out_col       = m_out_col_reg;
    assign m_product_value = m_product_value_reg;
    assign m_last          = m_last_reg;

endmodule
